// ===== hw/rtl/uam_pkg.sv =====
// Shared types and codes for the undirected adjacency matrix block.
// Used by uam_front, uam_queue, uam_back and the top level.
package uam_pkg;

  localparam int VTX_W   = 3;
  localparam int CFG_W   = 4;
  localparam int COUNT_W = 6;

  typedef logic [VTX_W-1:0]   vtx_t;
  typedef logic [CFG_W-1:0]   cfg_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  typedef enum logic [2:0] {
    K_INSERT,
    K_REMOVE,
    K_LIST,
    K_BAD,
    K_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    vtx_t      v;
    vtx_t      w;
  } cmd_t;

endpackage

// ===== hw/rtl/uam_front.sv =====
// Front end: accepts input transactions and classifies them into commands.
// Depends on uam_pkg.
module uam_front (
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     opcode,
  input  uam_pkg::vtx_t  from_vertex,
  input  uam_pkg::vtx_t  to_vertex,
  input  uam_pkg::cfg_t  n_eff,
  input  logic           q_full,
  output logic           q_push,
  output uam_pkg::cmd_t  q_cmd
);

  logic out_of_range;

  assign out_of_range = ({1'b0, from_vertex} >= n_eff) || ({1'b0, to_vertex} >= n_eff);

  always_comb begin
    q_cmd.v = from_vertex;
    q_cmd.w = to_vertex;
    case (opcode)
      uam_pkg::OP_INSERT: q_cmd.kind = out_of_range ? uam_pkg::K_BAD : uam_pkg::K_INSERT;
      uam_pkg::OP_REMOVE: q_cmd.kind = out_of_range ? uam_pkg::K_BAD : uam_pkg::K_REMOVE;
      uam_pkg::OP_LIST:   q_cmd.kind = uam_pkg::K_LIST;
      default:            q_cmd.kind = uam_pkg::K_NOP;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ===== hw/rtl/uam_queue.sv =====
// Two-entry command queue between front end and back end.
// Depends on uam_pkg.
module uam_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  uam_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output uam_pkg::cmd_t head
);

  uam_pkg::cmd_t slot0;
  uam_pkg::cmd_t slot1;
  logic [1:0]    fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head      = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: fill <= fill + 2'd1;
        2'b01: fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (fill == 2'd0) begin
          slot0 <= push_cmd;
        end else begin
          slot1 <= push_cmd;
        end
      end
      2'b01: slot0 <= slot1;
      2'b11: begin
        if (fill == 2'd1) begin
          slot0 <= push_cmd;
        end else begin
          slot0 <= slot1;
          slot1 <= push_cmd;
        end
      end
      default: slot0 <= slot0;
    endcase
  end

endmodule

// ===== hw/rtl/uam_back.sv =====
// Back end: holds the adjacency matrix and edge count, executes commands
// and walks the upper triangle for listings. Depends on uam_pkg.
module uam_back #(
  parameter int MAX_VERTICES = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  uam_pkg::cfg_t   n_eff,
  input  logic            q_not_empty,
  input  uam_pkg::cmd_t   q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output uam_pkg::vtx_t   out_from,
  output uam_pkg::vtx_t   out_to,
  output logic            has_edge,
  output uam_pkg::count_t edge_count,
  output logic            bad_vertex,
  output logic            last
);

  localparam int VIDX_W    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int MAX_EDGES = MAX_VERTICES * (MAX_VERTICES + 1) / 2;

  typedef enum logic {S_IDLE, S_LIST} state_t;

  state_t                  state;
  logic [MAX_VERTICES-1:0] adj  [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_next [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] pend [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] pend_init [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] pend_clr  [MAX_VERTICES];
  logic [VIDX_W-1:0]       row;
  logic [VIDX_W-1:0]       col;
  uam_pkg::count_t         count;
  uam_pkg::count_t         count_ins;
  uam_pkg::count_t         count_rem;
  uam_pkg::count_t         count_next;
  logic                    out_load;
  logic [VIDX_W-1:0]       vi;
  logic [VIDX_W-1:0]       wi;
  logic                    cur_bit;
  logic                    init_any;
  logic                    clr_any;
  logic                    row_end;
  logic                    adj_write;
  logic                    list_start;

  assign out_load   = !out_valid || !out_stall;
  assign q_pop      = (state == S_IDLE) && out_load && q_not_empty;
  assign vi         = q_head.v[VIDX_W-1:0];
  assign wi         = q_head.w[VIDX_W-1:0];
  assign cur_bit    = adj[vi][wi];
  assign count_ins  = cur_bit ? count : count + uam_pkg::count_t'(1);
  assign count_rem  = cur_bit ? count - uam_pkg::count_t'(1) : count;
  assign row_end    = (uam_pkg::cfg_t'(col) + uam_pkg::cfg_t'(1)) >= n_eff;
  assign adj_write  = q_head.kind inside {uam_pkg::K_INSERT, uam_pkg::K_REMOVE};
  assign list_start = (q_head.kind == uam_pkg::K_LIST) && init_any;

  always_comb begin
    case (q_head.kind)
      uam_pkg::K_INSERT: count_next = count_ins;
      uam_pkg::K_REMOVE: count_next = count_rem;
      default:           count_next = count;
    endcase
  end

  always_comb begin
    init_any = 1'b0;
    clr_any  = 1'b0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      for (int j = 0; j < MAX_VERTICES; j++) begin
        pend_init[i][j] = adj[i][j] && (i < j) && (uam_pkg::cfg_t'(j) < n_eff);
      end
      adj_next[i] = adj[i];
      if (VIDX_W'(i) == vi) adj_next[i][wi] = (q_head.kind == uam_pkg::K_INSERT);
      if (VIDX_W'(i) == wi) adj_next[i][vi] = (q_head.kind == uam_pkg::K_INSERT);
      pend_clr[i] = pend[i];
      if (VIDX_W'(i) == row) begin
        pend_clr[i][col] = 1'b0;
      end
      init_any = init_any || (|pend_init[i]);
      clr_any  = clr_any || (|pend_clr[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        adj[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            out_valid  <= !list_start;
            out_from   <= '0;
            out_to     <= '0;
            has_edge   <= 1'b0;
            bad_vertex <= (q_head.kind == uam_pkg::K_BAD);
            last       <= 1'b1;
            edge_count <= count_next;
            count      <= count_next;
            if (adj_write) begin
              for (int i = 0; i < MAX_VERTICES; i++) begin
                adj[i] <= adj_next[i];
              end
            end
            if (list_start) begin
              state <= S_LIST;
              pend  <= pend_init;
              row   <= '0;
              col   <= VIDX_W'(1);
            end
          end else if (out_load) begin
            out_valid <= 1'b0;
          end
        end
        S_LIST: begin
          if (out_load) begin
            out_valid <= pend[row][col];
            if (pend[row][col]) begin
              out_from   <= uam_pkg::vtx_t'(row);
              out_to     <= uam_pkg::vtx_t'(col);
              has_edge   <= 1'b1;
              bad_vertex <= 1'b0;
              edge_count <= count;
              last       <= !clr_any;
              pend       <= pend_clr;
              if (!clr_any) begin
                state <= S_IDLE;
              end
            end
            if (row_end) begin
              row <= row + VIDX_W'(1);
              col <= row + VIDX_W'(2);
            end else begin
              col <= col + VIDX_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_list_has_work: assert property (@(posedge clk) disable iff (rst)
    state == S_LIST |-> clr_any || pend[row][col])
    else $error("listing active with nothing pending");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= uam_pkg::count_t'(MAX_EDGES))
    else $error("edge count exceeds matrix capacity");
  a_edge_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_edge |-> out_from < out_to)
    else $error("listed edge not in upper triangle");
  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_vertex |-> last && !has_edge)
    else $error("bad vertex result not a lone final result");
  a_no_pop_listing: assert property (@(posedge clk) disable iff (rst)
    state == S_LIST |-> !q_pop)
    else $error("command popped during listing");
`endif

endmodule

// ===== hw/rtl/undirected_adjacency_matrix_top.sv =====
// Undirected adjacency matrix top level: configuration register, front end,
// command queue and back end. Depends on uam_pkg, uam_front, uam_queue, uam_back.
//
// Usage:
//   Input channel (in_valid / in_stall) carries opcode, from_vertex, to_vertex.
//   Output channel (out_valid / out_stall) carries out_from, out_to, has_edge,
//   edge_count, bad_vertex, last; last marks the final result of a transaction.
//   Config channel (cfg_valid / cfg_ready / cfg_data) writes num_vertices;
//   cfg_ready is always high. Write it only while the block is idle.
//   Insert, remove, bad and unused opcodes raise out_valid once the command has
//   passed the queue and the back-end result register, and sustain one
//   transaction per cycle while out_stall is low and no listing runs. A listing
//   walks the upper triangle of the vertices in use, one matrix position per
//   cycle while out_stall is low.
//   A two-entry queue lets the front end keep accepting while the back end works.
//   Reset clears the matrix, the edge count and the queue; num_vertices
//   returns to 8. While out_stall and out_valid are both high, the result
//   register holds and the back end waits; the queue fills, then in_stall rises.
module undirected_adjacency_matrix_top #(
  parameter int MAX_VERTICES = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            opcode,
  input  logic [2:0]            from_vertex,
  input  logic [2:0]            to_vertex,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_from,
  output logic [2:0]            out_to,
  output logic                  has_edge,
  output logic [5:0]            edge_count,
  output logic                  bad_vertex,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_data
);

  uam_pkg::cfg_t num_vertices;
  uam_pkg::cfg_t n_eff;
  uam_pkg::cmd_t push_cmd;
  uam_pkg::cmd_t head;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_not_empty;

  assign cfg_ready = 1'b1;
  assign n_eff = (num_vertices > uam_pkg::cfg_t'(MAX_VERTICES)) ?
                 uam_pkg::cfg_t'(MAX_VERTICES) : num_vertices;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vertices <= uam_pkg::cfg_t'(8);
    end else if (cfg_valid && cfg_ready) begin
      num_vertices <= cfg_data;
    end
  end

  uam_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .from_vertex (from_vertex),
    .to_vertex   (to_vertex),
    .n_eff       (n_eff),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  uam_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  uam_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .n_eff       (n_eff),
    .q_not_empty (q_not_empty),
    .q_head      (head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_from    (out_from),
    .out_to      (out_to),
    .has_edge    (has_edge),
    .edge_count  (edge_count),
    .bad_vertex  (bad_vertex),
    .last        (last)
  );

endmodule
